@@ hdl/uggc_pkg.sv @@
// shared constants and types of the go-to-goal controller
// angle format, cordic arctangent table, square root sizes, register codes
// no dependencies
package uggc_pkg;

  // angles are radians in q.16, carried as signed 20 bit values
  localparam int AW = 20;

  localparam logic signed [AW-1:0] ANG_PI      = 20'sd205887;
  localparam logic signed [AW-1:0] ANG_HALF_PI = 20'sd102944;
  localparam logic signed [AW-1:0] ANG_TWO_PI  = 20'sd411775;

  // cordic datapath of the sine/cosine unit and its start value (1/gain in q.16)
  localparam int CS_W = 20;
  localparam logic signed [CS_W-1:0] CORDIC_INV_GAIN = 20'sd39797;

  localparam int MAX_ITER = 24;

  // atan(2^-i) in q.16
  localparam logic signed [AW-1:0] ATAN_TABLE [0:MAX_ITER-1] = '{
    20'sd51472, 20'sd30385, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024,  20'sd512,   20'sd256,   20'sd128,  20'sd64,   20'sd32,
    20'sd16,    20'sd8,     20'sd4,     20'sd2,    20'sd1,    20'sd0,
    20'sd0,     20'sd0,     20'sd0,     20'sd0,    20'sd0,    20'sd0
  };

  // squared distance and its q.16 square root
  localparam int SQ_W   = 34;
  localparam int ROOT_W = 25;

  // configuration register codes
  typedef enum logic [1:0] {
    REG_GAIN_DISTANCE = 2'd0,
    REG_GAIN_HEADING  = 2'd1
  } cfg_reg_t;

endpackage

@@ hdl/uggc_cordic.sv @@
// unrolled cordic, one register stage per iteration plus one range-fold stage
// vectoring mode gives atan2(y, x), rotation mode gives cos/sin of z
// depends on uggc_pkg
module uggc_cordic #(
  parameter int W      = 20,
  parameter int N      = 16,
  parameter bit VECTOR = 1'b1
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [W-1:0]           x_i,
  input  logic signed [W-1:0]           y_i,
  input  logic signed [uggc_pkg::AW-1:0] z_i,
  output logic signed [W-1:0]           x_o,
  output logic signed [W-1:0]           y_o,
  output logic signed [uggc_pkg::AW-1:0] z_o
);

  logic signed [W-1:0]            x_r [0:N];
  logic signed [W-1:0]            y_r [0:N];
  logic signed [uggc_pkg::AW-1:0] z_r [0:N];
  logic                           f_r [0:N];

  logic signed [W-1:0]            px_nxt;
  logic signed [W-1:0]            py_nxt;
  logic signed [uggc_pkg::AW-1:0] pz_nxt;
  logic                           pf_nxt;

  // fold stage: quadrant pre-rotation (vectoring) or fold by pi (rotation)
  always_comb begin
    px_nxt = x_i;
    py_nxt = y_i;
    pz_nxt = z_i;
    pf_nxt = 1'b0;
    if (VECTOR) begin
      pz_nxt = '0;
      pf_nxt = (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        if (y_i >= 0) begin
          px_nxt = y_i;
          py_nxt = -x_i;
          pz_nxt = uggc_pkg::ANG_HALF_PI;
        end else begin
          px_nxt = -y_i;
          py_nxt = x_i;
          pz_nxt = -uggc_pkg::ANG_HALF_PI;
        end
      end
    end else begin
      if (z_i > uggc_pkg::ANG_HALF_PI) begin
        pz_nxt = z_i - uggc_pkg::ANG_PI;
        pf_nxt = 1'b1;
      end else if (z_i < -uggc_pkg::ANG_HALF_PI) begin
        pz_nxt = z_i + uggc_pkg::ANG_PI;
        pf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= px_nxt;
      y_r[0] <= py_nxt;
      z_r[0] <= pz_nxt;
      f_r[0] <= pf_nxt;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;
    logic                up;

    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    // turn direction: toward y = 0 when vectoring, toward z = 0 when rotating
    assign up = VECTOR ? (y_r[i] < 0) : (z_r[i] >= 0);

    always_ff @(posedge clk) begin
      if (en) begin
        if (up) begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - uggc_pkg::ATAN_TABLE[i];
        end else begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + uggc_pkg::ATAN_TABLE[i];
        end
        f_r[i+1] <= f_r[i];
      end
    end
  end

  // flag: zero vector (angle 0) or folded angle (negate both results)
  assign x_o = f_r[N] ? -x_r[N] : x_r[N];
  assign y_o = f_r[N] ? -y_r[N] : y_r[N];
  assign z_o = f_r[N] ? '0 : z_r[N];

endmodule

@@ hdl/uggc_sqrt.sv @@
// pipelined digit-by-digit integer square root, one root bit per stage
// returns floor(sqrt(sq_i * 2^16))
// depends on uggc_pkg
module uggc_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [uggc_pkg::SQ_W-1:0]     sq_i,
  output logic [uggc_pkg::ROOT_W-1:0]   root_o
);

  localparam int RTW = uggc_pkg::ROOT_W;
  localparam int VW  = 2 * RTW;
  localparam int RW  = RTW + 3;

  logic [RTW-1:0] root_r [0:RTW-1];
  logic [RW-1:0]  rem_r  [0:RTW-2];
  logic [VW-1:0]  v_r    [0:RTW-2];

  for (genvar k = 0; k < RTW; k++) begin : g_stage
    logic [RW-1:0]  rem_in;
    logic [RTW-1:0] root_in;
    logic [VW-1:0]  v_in;
    logic [RW-1:0]  t;
    logic [RW-1:0]  trial;
    logic           take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_in    = {sq_i, {(VW-uggc_pkg::SQ_W){1'b0}}};
    end else begin : g_rest
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign v_in    = v_r[k-1];
    end

    assign t     = {rem_in[RW-3:0], v_in[VW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign take  = (t >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= {root_in[RTW-2:0], take};
      end
    end

    if (k < RTW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? (t - trial) : t;
          v_r[k]   <= v_in << 2;
        end
      end
    end
  end

  assign root_o = root_r[RTW-1];

endmodule

@@ hdl/unicycle_go_to_goal_controller.sv @@
// top level of the unicycle go-to-goal controller
// fixed point pipeline: yaw and bearing cordics, square root, sine/cosine cordic, gains
// depends on uggc_pkg, uggc_cordic, uggc_sqrt
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------------------------
//   in      | in_valid / in_ready   | target x/y, robot x/y (q8.8), quaternion (q1.14)
//   out     | out_valid / out_ready | forward speed, turn rate (q8.8, saturated)
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (q4.12 gains)
//
// one beat is accepted every cycle while the skid register is empty; the latency is
// set by the yaw/bearing cordic, the sine/cosine cordic and the 25-stage square root
// reset (rst_n low at a clock edge) empties the pipeline and sets both gains to 0.5
// a result that cannot leave goes to a one-beat skid register; while that is full the
// whole pipeline holds and in_ready is low, so no beat is dropped or repeated
// cfg_ready is always high
module unicycle_go_to_goal_controller #(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_target_x,
  input  logic signed [15:0] in_target_y,
  input  logic signed [15:0] in_robot_x,
  input  logic signed [15:0] in_robot_y,
  input  logic signed [15:0] in_orient_w,
  input  logic signed [15:0] in_orient_x,
  input  logic signed [15:0] in_orient_y,
  input  logic signed [15:0] in_orient_z,

  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_forward_speed,
  output logic signed [15:0] out_turn_rate,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int AW      = uggc_pkg::AW;
  localparam int CSW     = uggc_pkg::CS_W;
  localparam int RTW     = uggc_pkg::ROOT_W;
  localparam int YAW_W   = 38;   // cordic width for the quaternion operands
  localparam int BRG_W   = 20;   // cordic width for the position difference
  localparam int ANG_LAT = 2 * ANGLE_ITERATIONS + 3;
  localparam int ALN     = (ANG_LAT > RTW) ? ANG_LAT : RTW;
  localparam int D_DLY   = ALN - RTW;
  localparam int SC_DLY  = ALN - ANG_LAT;
  localparam int E_DLY   = ANGLE_ITERATIONS + 1;
  localparam int VL      = ALN + 4;

  localparam logic signed [35:0] CY_ONE = 36'sd268435456;  // 1.0 in q.28

  // ---------------------------------------------------------------- config
  logic [15:0] k1_r;
  logic [15:0] k2_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_r <= 16'd2048;
      k2_r <= 16'd2048;
    end else if (cfg_valid) begin
      case (cfg_index)
        uggc_pkg::REG_GAIN_DISTANCE: k1_r <= cfg_data;
        uggc_pkg::REG_GAIN_HEADING:  k2_r <= cfg_data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  logic          pipe_en;
  logic          skid_full_r;
  logic [VL-1:0] vld_r;

  // the pipeline only holds while the skid register is occupied
  assign pipe_en  = !skid_full_r;
  assign in_ready = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[VL-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------- stage 1: products
  logic signed [16:0] dx_r;
  logic signed [16:0] dy_r;
  logic signed [31:0] pwz_r;
  logic signed [31:0] pxy_r;
  logic signed [31:0] pyy_r;
  logic signed [31:0] pzz_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dx_r  <= 17'(in_target_x) - 17'(in_robot_x);
      dy_r  <= 17'(in_target_y) - 17'(in_robot_y);
      pwz_r <= in_orient_w * in_orient_z;
      pxy_r <= in_orient_x * in_orient_y;
      pyy_r <= in_orient_y * in_orient_y;
      pzz_r <= in_orient_z * in_orient_z;
    end
  end

  // ---------------------------------------------------------------- stage 2: atan2 operands
  logic signed [35:0]            sy_r;
  logic signed [35:0]            cy_r;
  logic signed [16:0]            dx2_r;
  logic signed [16:0]            dy2_r;
  logic [uggc_pkg::SQ_W-1:0]     sq_r;
  logic signed [34:0]            sq_nxt;

  assign sq_nxt = 35'(dx_r) * 35'(dx_r) + 35'(dy_r) * 35'(dy_r);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sy_r  <= (36'(pwz_r) + 36'(pxy_r)) <<< 1;
      cy_r  <= CY_ONE - ((36'(pyy_r) + 36'(pzz_r)) <<< 1);
      dx2_r <= dx_r;
      dy2_r <= dy_r;
      sq_r  <= sq_nxt[uggc_pkg::SQ_W-1:0];
    end
  end

  // ---------------------------------------------------------------- yaw, bearing, distance
  logic signed [AW-1:0]  yaw;
  logic signed [AW-1:0]  bearing;
  logic [RTW-1:0]        dist_q16;

  uggc_cordic #(.W(YAW_W), .N(ANGLE_ITERATIONS), .VECTOR(1'b1)) u_yaw (
    .clk (clk),
    .en  (pipe_en),
    .x_i (YAW_W'(cy_r)),
    .y_i (YAW_W'(sy_r)),
    .z_i ('0),
    .x_o (),
    .y_o (),
    .z_o (yaw)
  );

  uggc_cordic #(.W(BRG_W), .N(ANGLE_ITERATIONS), .VECTOR(1'b1)) u_bearing (
    .clk (clk),
    .en  (pipe_en),
    .x_i (BRG_W'(dx2_r)),
    .y_i (BRG_W'(dy2_r)),
    .z_i ('0),
    .x_o (),
    .y_o (),
    .z_o (bearing)
  );

  uggc_sqrt u_sqrt (
    .clk    (clk),
    .en     (pipe_en),
    .sq_i   (sq_r),
    .root_o (dist_q16)
  );

  // ---------------------------------------------------------------- heading error, single wrap
  logic signed [AW:0]   diff;
  logic signed [AW:0]   wrap;
  logic signed [AW-1:0] err_r;

  assign diff = (AW+1)'(yaw) - (AW+1)'(bearing);

  always_comb begin
    wrap = diff;
    if (diff > (AW+1)'(uggc_pkg::ANG_PI)) begin
      wrap = diff - (AW+1)'(uggc_pkg::ANG_TWO_PI);
    end else if (diff < -(AW+1)'(uggc_pkg::ANG_PI)) begin
      wrap = diff + (AW+1)'(uggc_pkg::ANG_TWO_PI);
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      err_r <= wrap[AW-1:0];
    end
  end

  // ---------------------------------------------------------------- sine and cosine
  logic signed [CSW-1:0] cos_v;
  logic signed [CSW-1:0] sin_v;

  uggc_cordic #(.W(CSW), .N(ANGLE_ITERATIONS), .VECTOR(1'b0)) u_sincos (
    .clk (clk),
    .en  (pipe_en),
    .x_i (uggc_pkg::CORDIC_INV_GAIN),
    .y_i ('0),
    .z_i (err_r),
    .x_o (cos_v),
    .y_o (sin_v),
    .z_o ()
  );

  // error rides alongside the sine/cosine cordic
  logic signed [AW-1:0] err_e_r [0:E_DLY-1];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      err_e_r[0] <= err_r;
      for (int j = 1; j < E_DLY; j++) begin
        err_e_r[j] <= err_e_r[j-1];
      end
    end
  end

  // ---------------------------------------------------------------- align the two paths
  logic [RTW-1:0]        d_al;
  logic signed [CSW-1:0] c_al;
  logic signed [CSW-1:0] s_al;
  logic signed [AW-1:0]  e_al;

  if (D_DLY == 0) begin : g_d_direct
    assign d_al = dist_q16;
  end else begin : g_d_delay
    logic [RTW-1:0] dd_r [0:D_DLY-1];
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        dd_r[0] <= dist_q16;
        for (int j = 1; j < D_DLY; j++) begin
          dd_r[j] <= dd_r[j-1];
        end
      end
    end
    assign d_al = dd_r[D_DLY-1];
  end

  if (SC_DLY == 0) begin : g_sc_direct
    assign c_al = cos_v;
    assign s_al = sin_v;
    assign e_al = err_e_r[E_DLY-1];
  end else begin : g_sc_delay
    logic signed [CSW-1:0] cd_r [0:SC_DLY-1];
    logic signed [CSW-1:0] sd_r [0:SC_DLY-1];
    logic signed [AW-1:0]  ed_r [0:SC_DLY-1];
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        cd_r[0] <= cos_v;
        sd_r[0] <= sin_v;
        ed_r[0] <= err_e_r[E_DLY-1];
        for (int j = 1; j < SC_DLY; j++) begin
          cd_r[j] <= cd_r[j-1];
          sd_r[j] <= sd_r[j-1];
          ed_r[j] <= ed_r[j-1];
        end
      end
    end
    assign c_al = cd_r[SC_DLY-1];
    assign s_al = sd_r[SC_DLY-1];
    assign e_al = ed_r[SC_DLY-1];
  end

  // ---------------------------------------------------------------- f1: d*cos, sin*cos
  logic signed [45:0]   pdc_r;
  logic signed [39:0]   psc_r;
  logic signed [AW-1:0] e1_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      pdc_r <= 46'($signed({1'b0, d_al})) * 46'(c_al);
      psc_r <= 40'(s_al) * 40'(c_al);
      e1_r  <= e_al;
    end
  end

  // ---------------------------------------------------------------- f2: gains
  logic signed [46:0] fk_r;
  logic signed [40:0] tk_r;
  logic signed [36:0] ek_r;
  logic signed [16:0] k1_s;
  logic signed [16:0] k2_s;

  assign k1_s = $signed({1'b0, k1_r});
  assign k2_s = $signed({1'b0, k2_r});

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      fk_r <= 47'($signed(pdc_r[45:16])) * 47'(k1_s);
      tk_r <= 41'($signed(psc_r[39:16])) * 41'(k1_s);
      ek_r <= 37'(e1_r) * 37'(k2_s);
    end
  end

  // ---------------------------------------------------------------- f3: scale, saturate
  logic signed [42:0] turn_sum;
  logic signed [26:0] fwd_w;
  logic signed [22:0] turn_w;
  logic signed [15:0] fwd_sat;
  logic signed [15:0] turn_sat;

  assign turn_sum = -43'(tk_r) - 43'(ek_r);
  assign fwd_w    = fk_r[46:20];
  assign turn_w   = turn_sum[42:20];

  always_comb begin
    if (fwd_w > 27'sd32767) begin
      fwd_sat = 16'sh7fff;
    end else if (fwd_w < -27'sd32768) begin
      fwd_sat = 16'sh8000;
    end else begin
      fwd_sat = fwd_w[15:0];
    end
    if (turn_w > 23'sd32767) begin
      turn_sat = 16'sh7fff;
    end else if (turn_w < -23'sd32768) begin
      turn_sat = 16'sh8000;
    end else begin
      turn_sat = turn_w[15:0];
    end
  end

  // ---------------------------------------------------------------- output and skid registers
  logic               tail_v;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic               skid_full_nxt;
  logic               out_load;
  logic               skid_load;
  logic signed [15:0] out_fwd_r;
  logic signed [15:0] out_turn_r;
  logic signed [15:0] skid_fwd_r;
  logic signed [15:0] skid_turn_r;

  assign tail_v = vld_r[VL-1] && pipe_en;

  always_comb begin
    out_valid_nxt = out_valid_r;
    skid_full_nxt = skid_full_r;
    out_load      = 1'b0;
    skid_load     = 1'b0;
    if (skid_full_r) begin
      // held beat moves up once the output beat is taken
      if (out_ready) begin
        out_load      = 1'b1;
        skid_full_nxt = 1'b0;
      end
    end else if (tail_v) begin
      if (!out_valid_r || out_ready) begin
        out_load      = 1'b1;
        out_valid_nxt = 1'b1;
      end else begin
        skid_load     = 1'b1;
        skid_full_nxt = 1'b1;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_fwd_r  <= skid_full_r ? skid_fwd_r  : fwd_sat;
      out_turn_r <= skid_full_r ? skid_turn_r : turn_sat;
    end
    if (skid_load) begin
      skid_fwd_r  <= fwd_sat;
      skid_turn_r <= turn_sat;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_forward_speed = out_fwd_r;
  assign out_turn_rate     = out_turn_r;

`ifndef SYNTH
  // a beat in the skid register always has a beat ahead of it
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  // a held skid beat stays put until the output side moves
  a_skid_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (skid_full_r && !out_ready) |=> (skid_full_r && $stable(skid_fwd_r)
                                     && $stable(skid_turn_r)))
    else $error("skid beat lost during stall");

  // a frozen pipeline keeps its valid bits
  a_pipe_frozen : assert property (@(posedge clk) disable iff (!rst_n)
    (!pipe_en) |=> $stable(vld_r))
    else $error("pipeline valid bits moved during stall");
`endif

endmodule

@@ tb/unicycle_go_to_goal_controller_tb.sv @@
// testbench of the unicycle go-to-goal controller: directed table, then random phases
// every command is checked against a fixed point model of the controller kept here
// depends on uggc_pkg and unicycle_go_to_goal_controller
module unicycle_go_to_goal_controller_tb;

  localparam int ITERS      = 16;     // matches the block's default angle iterations
  localparam int DRAIN_WAIT = 60;     // idle wait after the last due command has come out
  localparam int STALL_MAX  = 5000;   // cycles with no beat before the watchdog fires

  typedef struct {
    logic signed [15:0] tx, ty, rx, ry, qw, qx, qy, qz;
    bit                 pin_fwd;      // forward speed typed in by hand
    logic signed [15:0] fwd;
  } goal_row_t;

  typedef struct {
    logic signed [15:0] fwd;
    logic signed [15:0] turn;
  } drive_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_target_x = '0, in_target_y = '0, in_robot_x = '0, in_robot_y = '0;
  logic signed [15:0] in_orient_w = '0, in_orient_x = '0, in_orient_y = '0, in_orient_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_forward_speed, out_turn_rate;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  // forward speed override that travels with the beat
  logic               pin_fwd_en = 1'b0;
  logic signed [15:0] pin_fwd_val = '0;

  // shadow copy of the gain registers
  longint k_dist = 2048;
  longint k_head = 2048;

  drive_cmd_t cmds_due[$];
  int errors = 0;
  int send_pct = 0;
  int recv_pct = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  unicycle_go_to_goal_controller #(.ANGLE_ITERATIONS(ITERS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_target_x(in_target_x), .in_target_y(in_target_y),
    .in_robot_x(in_robot_x), .in_robot_y(in_robot_y),
    .in_orient_w(in_orient_w), .in_orient_x(in_orient_x),
    .in_orient_y(in_orient_y), .in_orient_z(in_orient_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_forward_speed(out_forward_speed), .out_turn_rate(out_turn_rate),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ---------------- fixed point model ----------------

  // vectoring cordic, pre-rotated by a quarter turn when x is negative
  function automatic longint cordic_atan2(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = longint'(uggc_pkg::ANG_HALF_PI);
      end else begin
        x = -y; y = t; z = -longint'(uggc_pkg::ANG_HALF_PI);
      end
    end
    for (int i = 0; i < ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + longint'(uggc_pkg::ATAN_TABLE[i]);
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(uggc_pkg::ATAN_TABLE[i]);
      end
    end
    return z;
  endfunction

  // rotation cordic, folds angles past a quarter turn by half a turn
  function automatic void cordic_sincos(longint a, output longint s, output longint c);
    longint x, y, xs, ys;
    bit flip;
    x = longint'(uggc_pkg::CORDIC_INV_GAIN);
    y = 0;
    flip = 0;
    if (a > longint'(uggc_pkg::ANG_HALF_PI)) begin
      a = a - longint'(uggc_pkg::ANG_PI); flip = 1;
    end else if (a < -longint'(uggc_pkg::ANG_HALF_PI)) begin
      a = a + longint'(uggc_pkg::ANG_PI); flip = 1;
    end
    for (int i = 0; i < ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (a >= 0) begin
        x = x - ys; y = y + xs; a = a - longint'(uggc_pkg::ATAN_TABLE[i]);
      end else begin
        x = x + ys; y = y - xs; a = a + longint'(uggc_pkg::ATAN_TABLE[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b); r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic drive_cmd_t steer_command(goal_row_t r);
    drive_cmd_t cmd;
    longint dx, dy, qw, qx, qy, qz, sy, cy, yaw, brg, d_q16, err, s, c;
    dx = longint'(r.tx) - longint'(r.rx);
    dy = longint'(r.ty) - longint'(r.ry);
    qw = longint'(r.qw); qx = longint'(r.qx); qy = longint'(r.qy); qz = longint'(r.qz);
    sy = 2 * (qw * qz + qx * qy);
    cy = (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz);
    yaw = cordic_atan2(sy, cy);
    brg = cordic_atan2(dy, dx);
    d_q16 = floor_sqrt(longint'(dx * dx + dy * dy) << 16);
    err = yaw - brg;
    // heading wrap, once only
    if (err > longint'(uggc_pkg::ANG_PI)) err = err - longint'(uggc_pkg::ANG_TWO_PI);
    else if (err < -longint'(uggc_pkg::ANG_PI)) err = err + longint'(uggc_pkg::ANG_TWO_PI);
    cordic_sincos(err, s, c);
    cmd.fwd  = clamp16((((d_q16 * c) >>> 16) * k_dist) >>> 20);
    cmd.turn = clamp16((-k_dist * ((s * c) >>> 16) - k_head * err) >>> 20);
    return cmd;
  endfunction

  // ---------------- monitors ----------------

  task automatic report_mismatch(string what, logic signed [15:0] got, logic signed [15:0] want);
    errors++;
    if (errors <= 40)
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk) begin
    goal_row_t r;
    drive_cmd_t cmd;
    if (rst_n && cfg_valid && cfg_ready) begin
      // unknown indexes are ignored
      if (cfg_index == uggc_pkg::REG_GAIN_DISTANCE) k_dist = longint'(cfg_data);
      else if (cfg_index == uggc_pkg::REG_GAIN_HEADING) k_head = longint'(cfg_data);
    end
    if (rst_n && in_valid && in_ready) begin
      r.tx = in_target_x; r.ty = in_target_y; r.rx = in_robot_x; r.ry = in_robot_y;
      r.qw = in_orient_w; r.qx = in_orient_x; r.qy = in_orient_y; r.qz = in_orient_z;
      r.pin_fwd = 1'b0; r.fwd = '0;
      cmd = steer_command(r);
      if (pin_fwd_en) cmd.fwd = pin_fwd_val;
      cmds_due.push_back(cmd);
    end
    if (rst_n && out_valid && out_ready) begin
      if (cmds_due.size() == 0) begin
        report_mismatch("beat on out with none due", out_forward_speed, '0);
      end else begin
        cmd = cmds_due.pop_front();
        if (out_forward_speed !== cmd.fwd)
          report_mismatch("forward_speed", out_forward_speed, cmd.fwd);
        if (out_turn_rate !== cmd.turn)
          report_mismatch("turn_rate", out_turn_rate, cmd.turn);
      end
    end
  end

  // receiver stalls at the rate of the current phase
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_pct);

  // watchdog on cycles where no beat moves on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("FAIL unicycle_go_to_goal_controller");
      $finish;
    end
  end

  // ---------------- drivers ----------------

  // valid stays up between back-to-back beats; only a gap lowers it
  task automatic send_goal(goal_row_t r);
    while (send_pct > 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_target_x <= r.tx; in_target_y <= r.ty; in_robot_x <= r.rx; in_robot_y <= r.ry;
    in_orient_w <= r.qw; in_orient_x <= r.qx; in_orient_y <= r.qy; in_orient_z <= r.qz;
    pin_fwd_en <= r.pin_fwd;
    pin_fwd_val <= r.fwd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cmds_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_gain(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic goal_row_t goal(int tx, int ty, int rx, int ry,
                                     int qw, int qx, int qy, int qz);
    goal_row_t r;
    r.tx = 16'(tx); r.ty = 16'(ty); r.rx = 16'(rx); r.ry = 16'(ry);
    r.qw = 16'(qw); r.qx = 16'(qx); r.qy = 16'(qy); r.qz = 16'(qz);
    r.pin_fwd = 1'b0; r.fwd = '0;
    return r;
  endfunction

  // mostly nearby targets with in-range quaternions, some full-range noise
  function automatic goal_row_t random_goal();
    goal_row_t r;
    int pick;
    pick = $urandom_range(99);
    r = goal(0, 0, 0, 0, 0, 0, 0, 0);
    if (pick < 15) begin
      r.tx = 16'($urandom); r.ty = 16'($urandom); r.rx = 16'($urandom); r.ry = 16'($urandom);
    end else begin
      r.tx = 16'($urandom_range(4095) - 2048); r.ty = 16'($urandom_range(4095) - 2048);
      r.rx = 16'($urandom_range(4095) - 2048); r.ry = 16'($urandom_range(4095) - 2048);
    end
    if (pick % 10 == 3) begin
      r.qw = 16'($urandom); r.qx = 16'($urandom); r.qy = 16'($urandom); r.qz = 16'($urandom);
    end else if (pick % 10 < 3) begin
      // planar orientation: only w and z
      r.qw = 16'($urandom_range(32768) - 16384); r.qz = 16'($urandom_range(32768) - 16384);
    end else begin
      r.qw = 16'($urandom_range(32768) - 16384); r.qx = 16'($urandom_range(32768) - 16384);
      r.qy = 16'($urandom_range(32768) - 16384); r.qz = 16'($urandom_range(32768) - 16384);
    end
    return r;
  endfunction

  goal_row_t directed[$];

  initial begin
    goal_row_t r;
    int gd, gh;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // target on robot: no distance, so no forward speed
    r = goal(0, 0, 0, 0, 16384, 0, 0, 0); r.pin_fwd = 1; directed.push_back(r);
    r = goal(100, -7, 100, -7, 0, 0, 0, 16384); r.pin_fwd = 1; directed.push_back(r);
    // degenerate quaternion, both yaw operands zero
    directed.push_back(goal(512, 256, 0, 0, 0, 0, 8192, 8192));
    r = goal(-32768, 32767, -32768, 32767, 0, 0, 8192, 8192); r.pin_fwd = 1;
    directed.push_back(r);
    // position extremes, largest distance
    directed.push_back(goal(32767, 32767, -32768, -32768, 16384, 0, 0, 0));
    directed.push_back(goal(-32768, -32768, 32767, 32767, -16384, 0, 0, 0));
    directed.push_back(goal(32767, -32768, -32768, 32767, 0, 16384, 0, 0));
    directed.push_back(goal(-32768, 0, 32767, 0, 0, 0, 16384, 0));
    // heading wrap both ways: yaw near pi against bearing near -pi and back
    directed.push_back(goal(-1000, -3, 0, 0, 100, 0, 0, 16384));
    directed.push_back(goal(-1000, 3, 0, 0, -100, 0, 0, 16384));
    directed.push_back(goal(-1000, -1, 0, 0, 1, 0, 0, 16383));
    directed.push_back(goal(-1000, 1, 0, 0, -1, 0, 0, 16383));
    // quaternion components out of nominal range, used as given
    directed.push_back(goal(300, 300, 0, 0, -32768, -32768, -32768, -32768));
    directed.push_back(goal(-300, 300, 0, 0, 32767, 32767, 32767, 32767));
    directed.push_back(goal(0, 1, 0, 0, 16384, 16384, 16384, 16384));
    directed.push_back(goal(-1, 0, 0, 0, -16384, -16384, -16384, -16384));
    directed.push_back(goal(1, -1, 0, 0, 11585, 0, 0, -11585));

    foreach (directed[i]) send_goal(directed[i]);
    drain_pipeline();

    // saturation: top gains with far targets, then the remaining settings
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin gd = 65535; gh = 65535; send_pct = 0;  recv_pct = 0;  end
        1: begin gd = 0;     gh = 0;     send_pct = 82; recv_pct = 0;  end
        2: begin gd = 4096;  gh = 1;     send_pct = 0;  recv_pct = 82; end
        3: begin gd = 1;     gh = 65535; send_pct = 29; recv_pct = 29; end
        4: begin gd = 2048;  gh = 2048;  send_pct = 0;  recv_pct = 0;  end
        default: begin
          gd = $urandom_range(65535); gh = $urandom_range(65535);
          send_pct = (ph == 5) ? 82 : 29; recv_pct = 82;
        end
      endcase
      write_gain(uggc_pkg::REG_GAIN_DISTANCE, gd[15:0]);
      write_gain(uggc_pkg::REG_GAIN_HEADING, gh[15:0]);
      // unknown register codes must leave the gains alone
      if (ph == 2) write_gain(2'd2, 16'hffff);
      if (ph == 5) write_gain(2'd3, 16'h0000);
      if (ph == 0) begin
        send_goal(goal(32767, 32767, -32768, -32768, 16384, 0, 0, 0));
        send_goal(goal(-32768, 32767, 32767, -32768, 0, 0, 0, 16384));
        send_goal(goal(-1000, -3, 0, 0, 100, 0, 0, 16384));
      end
      for (int n = 0; n < 220; n++) begin
        // sender holds off until everything in flight has come out
        if (ph == 3 && n == 110) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (cmds_due.size() != 0) @(posedge clk);
        end
        send_goal(random_goal());
      end
      drain_pipeline();
    end

    if (errors == 0 && cmds_due.size() == 0) begin
      $display("PASS unicycle_go_to_goal_controller");
    end else begin
      $display("FAIL unicycle_go_to_goal_controller");
    end
    $finish;
  end

endmodule
